// ----- rtl/calendar_clock_counter_top_macros.svh -----
// assertion macros for the calendar clock counter
`ifndef CALENDAR_CLOCK_COUNTER_TOP_MACROS_SVH
`define CALENDAR_CLOCK_COUNTER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define CAL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CAL_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CAL_ASSERT(label, prop, msg)
`define CAL_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// ----- rtl/cal_pkg.sv -----
`default_nettype none
package cal_pkg;

  localparam int YEAR_W   = 16;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int HOUR_W   = 5;
  localparam int MIN_W    = 6;
  localparam int SEC_W    = 6;
  localparam int MOD25_W  = 5;
  localparam int FIELD_W  = YEAR_W + MONTH_W + DAY_W + HOUR_W + MIN_W + SEC_W;
  localparam int TDATA_W  = ((FIELD_W + 7) / 8) * 8;

  localparam int SEC_LIMIT    = 60;
  localparam int MIN_LIMIT    = 60;
  localparam int HOUR_LIMIT   = 24;
  localparam int MONTH_LAST   = 12;
  localparam int MOD25_LAST   = 24;

  localparam int DAYS_LONG     = 31;
  localparam int DAYS_SHORT    = 30;
  localparam int DAYS_FEB      = 28;
  localparam int DAYS_FEB_LEAP = 29;

  // residue of a year mod 25 from its nibbles: weights of 16^i mod 25
  localparam int NIB1_WEIGHT = 16;
  localparam int NIB2_WEIGHT = 6;
  localparam int NIB3_WEIGHT = 21;
  localparam int MOD_RECIP   = 41;
  localparam int MOD_SHIFT   = 10;
  localparam int MOD_BASE    = 25;
  localparam int MOD_SUM_W   = 10;
  localparam int MOD_PROD_W  = 15;

  localparam logic [YEAR_W-1:0]  RESET_YEAR   = 16'd2025;
  localparam logic [MONTH_W-1:0] RESET_MONTH  = 4'd1;
  localparam logic [DAY_W-1:0]   RESET_DAY    = 5'd1;
  localparam logic [HOUR_W-1:0]  RESET_HOUR   = 5'd12;
  localparam logic [MIN_W-1:0]   RESET_MINUTE = 6'd0;
  localparam logic [SEC_W-1:0]   RESET_SECOND = 6'd0;
  localparam logic [MOD25_W-1:0] RESET_MOD25  = 5'd0;

  typedef enum logic {
    CMD_TICK = 1'b0,
    CMD_LOAD = 1'b1
  } cal_cmd_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [HOUR_W-1:0]  hour;
    logic [MIN_W-1:0]   minute;
    logic [SEC_W-1:0]   second;
  } cal_time_t;

  typedef struct packed {
    cal_time_t          t;
    logic [MOD25_W-1:0] ymod25;
  } cal_state_t;

  typedef struct packed {
    cal_cmd_t           cmd;
    cal_time_t          set_time;
    logic [MOD25_W-1:0] set_mod25;
  } cal_item_t;

  function automatic logic [DAY_W-1:0] days_for_month(input logic [MONTH_W-1:0] m,
                                                      input logic leap);
    logic [DAY_W-1:0] d;
    case (m)
      4'd2:    d = leap ? DAY_W'(DAYS_FEB_LEAP) : DAY_W'(DAYS_FEB);
      4'd4:    d = DAY_W'(DAYS_SHORT);
      4'd6:    d = DAY_W'(DAYS_SHORT);
      4'd9:    d = DAY_W'(DAYS_SHORT);
      4'd11:   d = DAY_W'(DAYS_SHORT);
      default: d = DAY_W'(DAYS_LONG);
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/calendar_clock_counter_top.sv -----
// result path: input register, then the clock state register, which also holds the result
// throughput: one item per cycle while the output is not stalled by out_tready; the tick
//   carry chain and leap check sit between the two registers, the year mod 25 residue is
//   folded in ahead of the input register
// reset (synchronous, active low): 2025-01-01 12:00:00, both channels empty
`default_nettype none
`include "calendar_clock_counter_top_macros.svh"
module calendar_clock_counter_top (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  // set_year, set_month, set_day, set_hour, set_minute, set_second, zero pad
  input  wire logic [cal_pkg::TDATA_W-1:0]  in_tdata,
  // cmd
  input  wire logic                         in_tuser,
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  // year_now, month_now, day_now, hour_now, minute_now, second_now, zero pad
  output logic      [cal_pkg::TDATA_W-1:0]  out_tdata
);

  logic                        in_valid_r, in_valid_nxt;
  cal_pkg::cal_item_t          item_r, item_nxt;
  logic                        out_valid_r, out_valid_nxt;
  cal_pkg::cal_state_t         state_r, state_nxt;
  cal_pkg::cal_state_t         step_out;
  logic [cal_pkg::MOD25_W-1:0] set_mod25;
  logic                        advance;
  logic                        in_xfer;

  cal_mod25 u_mod25 (
    .year   (in_tdata[cal_pkg::YEAR_W-1:0]),
    .ymod25 (set_mod25)
  );

  cal_step u_step (
    .cur  (state_r),
    .item (item_r),
    .nxt  (step_out)
  );

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign in_xfer   = in_tvalid && in_tready;

  always_comb begin
    item_nxt              = item_r;
    item_nxt.cmd          = cal_pkg::cal_cmd_t'(in_tuser);
    item_nxt.set_time.year   = in_tdata[15:0];
    item_nxt.set_time.month  = in_tdata[19:16];
    item_nxt.set_time.day    = in_tdata[24:20];
    item_nxt.set_time.hour   = in_tdata[29:25];
    item_nxt.set_time.minute = in_tdata[35:30];
    item_nxt.set_time.second = in_tdata[41:36];
    item_nxt.set_mod25       = set_mod25;
    if (!in_xfer) begin
      item_nxt = item_r;
    end
  end

  always_comb begin
    in_valid_nxt = in_xfer ? 1'b1 : (advance ? 1'b0 : in_valid_r);
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
    state_nxt = advance ? step_out : state_r;
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    if (!rst_n) begin
      in_valid_r        <= 1'b0;
      out_valid_r       <= 1'b0;
      state_r.t.year    <= cal_pkg::RESET_YEAR;
      state_r.t.month   <= cal_pkg::RESET_MONTH;
      state_r.t.day     <= cal_pkg::RESET_DAY;
      state_r.t.hour    <= cal_pkg::RESET_HOUR;
      state_r.t.minute  <= cal_pkg::RESET_MINUTE;
      state_r.t.second  <= cal_pkg::RESET_SECOND;
      state_r.ymod25    <= cal_pkg::RESET_MOD25;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      state_r     <= state_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(cal_pkg::TDATA_W - cal_pkg::FIELD_W){1'b0}},
                       state_r.t.second, state_r.t.minute, state_r.t.hour,
                       state_r.t.day, state_r.t.month, state_r.t.year};

  // a tick always leaves second, minute, hour and month inside their ranges
  `CAL_ASSERT(a_tick_in_range, advance && (item_r.cmd == cal_pkg::CMD_TICK) |=> (state_r.t.second < 6'd60) && (state_r.t.minute < 6'd60) && (state_r.t.hour < 5'd24) && (state_r.t.month <= 4'd12), "tick left a field out of range")
  // the clock state only moves when an item goes through the step logic
  `CAL_ASSERT(a_state_hold, !advance |=> $stable(state_r), "clock state changed without an item")
  // a year carry on a tick lands in january
  `CAL_ASSERT(a_new_year, advance && (item_r.cmd == cal_pkg::CMD_TICK) && (step_out.t.year != state_r.t.year) |=> (state_r.t.month == 4'd1), "year carry not into january")
  // year residue mod 25 stays a valid residue
  `CAL_ASSERT(a_mod25_range, state_r.ymod25 <= 5'd24, "year residue out of range")
  // a new result only appears after an item moved through
  `CAL_ASSERT(a_out_from_step, $rose(out_valid_r) |-> $past(advance), "result without an item")
  `CAL_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid_r && !in_valid_r, "channels not empty after reset")

endmodule
`default_nettype wire

// ----- rtl/cal_mod25.sv -----
`default_nettype none
module cal_mod25 (
  input  wire logic [cal_pkg::YEAR_W-1:0]  year,
  output logic      [cal_pkg::MOD25_W-1:0] ymod25
);

  logic [cal_pkg::MOD_SUM_W-1:0]  nib_sum;
  logic [cal_pkg::MOD_PROD_W-1:0] recip_prod;
  logic [cal_pkg::MOD25_W-1:0]    quot;
  logic [cal_pkg::MOD_SUM_W-1:0]  rem;

  // fold nibbles with their weights mod 25, sum stays below 661
  assign nib_sum = cal_pkg::MOD_SUM_W'(year[3:0])
                 + cal_pkg::MOD_SUM_W'(year[7:4])
                   * cal_pkg::MOD_SUM_W'(cal_pkg::NIB1_WEIGHT)
                 + cal_pkg::MOD_SUM_W'(year[11:8])
                   * cal_pkg::MOD_SUM_W'(cal_pkg::NIB2_WEIGHT)
                 + cal_pkg::MOD_SUM_W'(year[15:12])
                   * cal_pkg::MOD_SUM_W'(cal_pkg::NIB3_WEIGHT);

  // 41/1024 approximates 1/25 closely enough over that range
  assign recip_prod = cal_pkg::MOD_PROD_W'(nib_sum) * cal_pkg::MOD_PROD_W'(cal_pkg::MOD_RECIP);
  assign quot       = recip_prod[cal_pkg::MOD_PROD_W-1:cal_pkg::MOD_SHIFT];
  assign rem        = nib_sum
                    - cal_pkg::MOD_SUM_W'(quot) * cal_pkg::MOD_SUM_W'(cal_pkg::MOD_BASE);
  assign ymod25     = rem[cal_pkg::MOD25_W-1:0];

endmodule
`default_nettype wire

// ----- rtl/cal_step.sv -----
`default_nettype none
module cal_step (
  input  wire cal_pkg::cal_state_t cur,
  input  wire cal_pkg::cal_item_t  item,
  output cal_pkg::cal_state_t      nxt
);

  logic                          leap;
  logic [cal_pkg::SEC_W-1:0]     sec_inc;
  logic [cal_pkg::MIN_W-1:0]     min_inc;
  logic [cal_pkg::HOUR_W-1:0]    hour_inc;
  logic [cal_pkg::DAY_W-1:0]     day_inc;
  logic [cal_pkg::MONTH_W-1:0]   month_inc;
  logic                          roll_s, roll_m, roll_h, roll_d, roll_mo;
  logic [cal_pkg::DAY_W-1:0]     month_days;
  logic [cal_pkg::YEAR_W-1:0]    year_inc;
  logic [cal_pkg::MOD25_W-1:0]   mod_inc;
  cal_pkg::cal_state_t           ticked;

  // leap: div by 4 and not by 100, or div by 400 (16 and 25)
  assign leap = ((cur.t.year[1:0] == 2'd0) && (cur.ymod25 != '0))
             || ((cur.t.year[3:0] == 4'd0) && (cur.ymod25 == '0));

  // every stage checks its own limit on each tick
  assign sec_inc  = cur.t.second + 1'b1;
  assign roll_s   = sec_inc >= cal_pkg::SEC_W'(cal_pkg::SEC_LIMIT);
  assign min_inc  = roll_s ? cur.t.minute + 1'b1 : cur.t.minute;
  assign roll_m   = min_inc >= cal_pkg::MIN_W'(cal_pkg::MIN_LIMIT);
  assign hour_inc = roll_m ? cur.t.hour + 1'b1 : cur.t.hour;
  assign roll_h   = hour_inc >= cal_pkg::HOUR_W'(cal_pkg::HOUR_LIMIT);
  assign day_inc  = roll_h ? cur.t.day + 1'b1 : cur.t.day;

  assign month_days = cal_pkg::days_for_month(cur.t.month, leap);
  assign roll_d     = day_inc > month_days;
  assign month_inc  = roll_d ? cur.t.month + 1'b1 : cur.t.month;
  assign roll_mo    = month_inc > cal_pkg::MONTH_W'(cal_pkg::MONTH_LAST);

  // year wraps to 0, whose residue is 0 as well
  assign year_inc = cur.t.year + 1'b1;
  assign mod_inc  = ((cur.t.year == '1)
                    || (cur.ymod25 == cal_pkg::MOD25_W'(cal_pkg::MOD25_LAST)))
                    ? '0 : cur.ymod25 + 1'b1;

  always_comb begin
    ticked.t.second = roll_s ? '0 : sec_inc;
    ticked.t.minute = roll_m ? '0 : min_inc;
    ticked.t.hour   = roll_h ? '0 : hour_inc;
    ticked.t.day    = roll_d ? cal_pkg::DAY_W'(1) : day_inc;
    ticked.t.month  = roll_mo ? cal_pkg::MONTH_W'(1) : month_inc;
    ticked.t.year   = roll_mo ? year_inc : cur.t.year;
    ticked.ymod25   = roll_mo ? mod_inc : cur.ymod25;
  end

  always_comb begin
    case (item.cmd)
      cal_pkg::CMD_LOAD: begin
        nxt.t      = item.set_time;
        nxt.ymod25 = item.set_mod25;
      end
      default: begin
        nxt = ticked;
      end
    endcase
  end

endmodule
`default_nettype wire
